// ----- src/qmr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the quantized MAC and requantize block.
// Used by qmr_front, qmr_queue, qmr_back, quantized_mac_requantize and qmr_checker; no dependencies.
package qmr_pkg;

  // Depth of the job queue between the accumulate front and the requantize back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgActZp = 2'd0,
    CfgWgtZp = 2'd1,
    CfgOutZp = 2'd2
  } cfg_idx_e;

  // Fixed-point constants of the requantize step.
  localparam int unsigned RndBit  = 30;
  localparam int unsigned HiShift = 31;

  // One finished dot product waiting for requantization.
  typedef struct packed {
    logic signed [31:0] acc;
    logic signed [31:0] mult;
    logic signed [5:0]  shift;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- src/qmr_front.sv -----
`timescale 1ns / 1ps
// Accumulate front: takes activation/weight pairs, keeps the running sum and
// hands finished sums to the job queue. Depends on qmr_pkg.
module qmr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic signed [7:0]   act_val_i,
  input  logic signed [7:0]   weight_val_i,
  input  logic signed [31:0]  bias_val_i,
  input  logic                first_i,
  input  logic                last_i,
  input  logic signed [31:0]  scale_mult_i,
  input  logic signed [5:0]   scale_shift_i,
  input  logic signed [7:0]   act_zp_i,
  input  logic signed [7:0]   wgt_zp_i,
  input  qmr_pkg::qstat_t     qstat_i,
  output logic                full_o,
  output logic                job_push_o,
  output qmr_pkg::job_t       job_o
);

  logic signed [8:0]  act_diff;
  logic signed [8:0]  wgt_diff;
  logic signed [17:0] prod;
  logic signed [31:0] base;
  logic signed [31:0] acc_d;
  logic signed [31:0] acc_q;
  logic               accept;

  assign act_diff = {act_val_i[7], act_val_i} - {act_zp_i[7], act_zp_i};
  assign wgt_diff = {weight_val_i[7], weight_val_i} - {wgt_zp_i[7], wgt_zp_i};
  assign prod     = act_diff * wgt_diff;

  // A first item restarts the sum from the bias; the add wraps modulo 2^32.
  assign base  = first_i ? bias_val_i : acc_q;
  assign acc_d = base + {{14{prod[17]}}, prod};

  assign accept     = push_i & ~qstat_i.full;
  assign full_o     = qstat_i.full;
  assign job_push_o = accept & last_i;

  always_comb begin
    job_o.acc   = acc_d;
    job_o.mult  = scale_mult_i;
    job_o.shift = scale_shift_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (accept) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ----- src/qmr_queue.sv -----
`timescale 1ns / 1ps
// Short job queue that decouples the accumulate front from the requantize back.
// Depends on qmr_pkg for the entry type and depth.
module qmr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qmr_pkg::job_t   job_i,
  input  logic            pop_i,
  output qmr_pkg::job_t   job_o,
  output qmr_pkg::qstat_t qstat_o
);

  qmr_pkg::job_t                    mem_q [qmr_pkg::QDepth];
  logic [qmr_pkg::QPtrW-1:0]        wr_ptr_q;
  logic [qmr_pkg::QPtrW-1:0]        rd_ptr_q;
  logic [qmr_pkg::QCntW-1:0]        cnt_q;
  logic                             do_push;
  logic                             do_pop;

  assign qstat_o.full  = (cnt_q == qmr_pkg::QCntW'(qmr_pkg::QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i & ~qstat_o.full;
  assign do_pop        = pop_i & ~qstat_o.empty;
  assign job_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == qmr_pkg::QPtrW'(qmr_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == qmr_pkg::QPtrW'(qmr_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/qmr_back.sv -----
`timescale 1ns / 1ps
// Requantize back: a small sequencer that scales one finished sum at a time and
// holds the result in an output register. Depends on qmr_pkg.
module qmr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qmr_pkg::job_t       job_i,
  input  qmr_pkg::qstat_t     qstat_i,
  output logic                job_pop_o,
  input  logic signed [7:0]   out_zp_i,
  input  logic                pop_i,
  output logic                empty_o,
  output logic signed [7:0]   out_q8_o,
  output logic signed [31:0]  raw_sum_o
);

  typedef enum logic [4:0] {
    SIdle = 5'b00001,
    SMul  = 5'b00010,
    SRnd  = 5'b00100,
    SShf  = 5'b01000,
    SOut  = 5'b10000
  } state_e;

  localparam logic signed [63:0] RndPos = 64'sd1 <<< qmr_pkg::RndBit;
  localparam logic signed [32:0] I32Max = 33'sd2147483647;
  localparam logic signed [32:0] I32Min = -33'sd2147483648;
  localparam logic signed [63:0] W32Max = 64'sd2147483647;
  localparam logic signed [63:0] W32Min = -64'sd2147483648;
  localparam logic signed [32:0] I8Max  = 33'sd127;
  localparam logic signed [32:0] I8Min  = -33'sd128;

  state_e             state_q, state_d;
  logic signed [31:0] acc_q;
  logic signed [31:0] mult_q;
  logic signed [5:0]  shift_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] rnd_q, rnd_d;
  logic signed [31:0] shf_q, shf_d;
  logic               res_valid_q;
  logic signed [7:0]  out_q8_q;
  logic signed [31:0] raw_q;

  logic signed [63:0] prod_d;
  logic signed [63:0] rnd_sum;
  logic signed [32:0] rnd_hi;
  logic [4:0]         rsh_amt;
  logic signed [32:0] rsh_sum;
  logic signed [32:0] rsh_res;
  logic [5:0]         lsh_amt;
  logic signed [63:0] lsh_wide;
  logic signed [32:0] zp_sum;
  logic signed [7:0]  q8_d;
  logic               out_free;

  // High product; the operands are sign-extended to the 64-bit result.
  assign prod_d = acc_q * mult_q;

  // Add 2^30 (subtract it for a negative product), then keep bits 63:31 and saturate to int32.
  always_comb begin
    rnd_sum = prod_q + (prod_q[63] ? -RndPos : RndPos);
    rnd_hi  = rnd_sum[63:qmr_pkg::HiShift];
    if (rnd_hi > I32Max) begin
      rnd_d = 32'sh7fffffff;
    end else if (rnd_hi < I32Min) begin
      rnd_d = 32'sh80000000;
    end else begin
      rnd_d = rnd_hi[31:0];
    end
  end

  // Rounded right shift for a positive shift, saturating left shift for a negative one.
  always_comb begin
    rsh_amt  = shift_q[4:0];
    rsh_sum  = {rnd_q[31], rnd_q} + (33'sd1 <<< (rsh_amt - 5'd1));
    rsh_res  = rsh_sum >>> rsh_amt;
    lsh_amt  = 6'(-shift_q);
    lsh_wide = {{32{rnd_q[31]}}, rnd_q} <<< lsh_amt[4:0];
    if (shift_q > 6'sd0) begin
      shf_d = rsh_res[31:0];
    end else if (shift_q < 6'sd0) begin
      if (rnd_q == '0) begin
        shf_d = '0;
      end else if (lsh_amt[5]) begin
        shf_d = rnd_q[31] ? 32'sh80000000 : 32'sh7fffffff;
      end else if (lsh_wide > W32Max) begin
        shf_d = 32'sh7fffffff;
      end else if (lsh_wide < W32Min) begin
        shf_d = 32'sh80000000;
      end else begin
        shf_d = lsh_wide[31:0];
      end
    end else begin
      shf_d = rnd_q;
    end
  end

  // Output zero point and int8 saturation.
  always_comb begin
    zp_sum = {shf_q[31], shf_q} + {{25{out_zp_i[7]}}, out_zp_i};
    if (zp_sum > I8Max) begin
      q8_d = 8'sd127;
    end else if (zp_sum < I8Min) begin
      q8_d = -8'sd128;
    end else begin
      q8_d = zp_sum[7:0];
    end
  end

  assign out_free  = ~res_valid_q | pop_i;
  assign job_pop_o = (state_q == SIdle) & ~qstat_i.empty;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (!qstat_i.empty) state_d = SMul;
      end
      SMul: state_d = SRnd;
      SRnd: state_d = SShf;
      SShf: state_d = SOut;
      SOut: begin
        if (out_free) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SOut && out_free) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      acc_q   <= job_i.acc;
      mult_q  <= job_i.mult;
      shift_q <= job_i.shift;
    end
    if (state_q == SMul) prod_q <= prod_d;
    if (state_q == SRnd) rnd_q <= rnd_d;
    if (state_q == SShf) shf_q <= shf_d;
    if (state_q == SOut && out_free) begin
      out_q8_q <= q8_d;
      raw_q    <= acc_q;
    end
  end

  assign empty_o   = ~res_valid_q;
  assign out_q8_o  = out_q8_q;
  assign raw_sum_o = raw_q;

endmodule

// ----- src/quantized_mac_requantize.sv -----
`timescale 1ns / 1ps
// Top level of the int8 multiply-accumulate and requantize block.
// Depends on qmr_pkg, qmr_front, qmr_queue and qmr_back.
//
//  Channel  | Handshake        | Carries
//  ---------+------------------+-----------------------------------------------
//  items    | push / full      | act_val_i, weight_val_i, bias_val_i, first_i,
//           |                  | last_i, scale_mult_i, scale_shift_i
//  results  | pop / empty      | out_q8_o, raw_sum_o
//  config   | cfg_we_i         | cfg_idx_i, cfg_wdata_i (three 8-bit zero points)
//
// The front takes one item per clock while the job queue has room; the
// multiply-accumulate of a pair finishes in the cycle of its transfer.
// Each last item becomes a job; the back sequencer takes each job through
// queue pop, 32x32 multiply, round and saturate, shift, and zero point and
// clamp in turn, and starts the next job only when the last one has left it.
// Runs of length one are thus limited by the back.
// Reset clears the accumulator, the zero points, the queue and the output
// valid flag; there is no clearing pass. A result waiting in the output register
// stalls only the back; the front keeps accepting until the queue fills.
module quantized_mac_requantize (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Item side.
  input  logic                              push,
  output logic                              full,
  input  logic signed [7:0]                 act_val_i,
  input  logic signed [7:0]                 weight_val_i,
  input  logic signed [31:0]                bias_val_i,
  input  logic                              first_i,
  input  logic                              last_i,
  input  logic signed [31:0]                scale_mult_i,
  input  logic signed [5:0]                 scale_shift_i,
  // Result side.
  output logic                              empty,
  input  logic                              pop,
  output logic signed [7:0]                 out_q8_o,
  output logic signed [31:0]                raw_sum_o,
  // Configuration writes.
  input  logic                              cfg_we_i,
  input  logic [qmr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [qmr_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  logic signed [7:0] act_zp_q;
  logic signed [7:0] wgt_zp_q;
  logic signed [7:0] out_zp_q;

  qmr_pkg::qstat_t   qstat;
  qmr_pkg::job_t     push_job;
  qmr_pkg::job_t     head_job;
  logic              job_push;
  logic              job_pop;

  // Zero point registers. An index past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_zp_q <= '0;
      wgt_zp_q <= '0;
      out_zp_q <= '0;
    end else if (cfg_we_i) begin
      case (qmr_pkg::cfg_idx_e'(cfg_idx_i))
        qmr_pkg::CfgActZp: act_zp_q <= cfg_wdata_i;
        qmr_pkg::CfgWgtZp: wgt_zp_q <= cfg_wdata_i;
        qmr_pkg::CfgOutZp: out_zp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The front owns the accumulator and only forwards completed runs.
  qmr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .act_val_i     (act_val_i),
    .weight_val_i  (weight_val_i),
    .bias_val_i    (bias_val_i),
    .first_i       (first_i),
    .last_i        (last_i),
    .scale_mult_i  (scale_mult_i),
    .scale_shift_i (scale_shift_i),
    .act_zp_i      (act_zp_q),
    .wgt_zp_i      (wgt_zp_q),
    .qstat_i       (qstat),
    .full_o        (full),
    .job_push_o    (job_push),
    .job_o         (push_job)
  );

  // Sum, multiplier and shift of each run travel together through the queue.
  qmr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (push_job),
    .pop_i   (job_pop),
    .job_o   (head_job),
    .qstat_o (qstat)
  );

  // The back requantizes and holds the result until it is taken.
  qmr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (head_job),
    .qstat_i   (qstat),
    .job_pop_o (job_pop),
    .out_zp_i  (out_zp_q),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_q8_o  (out_q8_o),
    .raw_sum_o (raw_sum_o)
  );

endmodule

// ----- src/qmr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for quantized_mac_requantize, attached by the bind below.
// Depends on qmr_pkg for the configuration port widths.
module qmr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic signed [7:0]             out_q8_o,
  input logic signed [31:0]            raw_sum_o,
  input logic                          cfg_we_i,
  input logic [qmr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [qmr_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  // While reset is held, no result is offered and the item side is open.
  a_reset_state: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("queue ports not idle during reset");

  // Right after reset is released, no result is offered yet.
  a_no_early_result: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty ##1 empty ##1 empty ##1 empty)
    else $error("result appeared too soon after reset");

  // A waiting result stays put until it is taken.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_q8_o) && $stable(raw_sum_o))
    else $error("waiting result changed before its transfer");

  // A configuration write never makes a result appear on its own.
  a_cfg_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && cfg_we_i && !push && $past(empty) && $past(!push)
      && $past(empty, 2) && $past(!push, 2) && $past(empty, 3) && $past(!push, 3)
      && $past(empty, 4) && $past(!push, 4) && $past(empty, 5) && $past(!push, 5)
      && $past(empty, 6) && $past(!push, 6) |=> empty)
    else $error("result appeared with no pending item");

endmodule

bind quantized_mac_requantize qmr_checker u_qmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_q8_o    (out_q8_o),
  .raw_sum_o   (raw_sum_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);
